// File: rtl/core/hbtm_pkg.sv
// ============================================================================
// Heartbeat timeout monitor package
// Shared widths, register map, transition codes, request modes and timeout reset value.
// ============================================================================
`default_nettype none

package hbtm_pkg;

   // Field widths of the request and result.
   localparam int unsigned CHANNEL_W    = 2;
   localparam int unsigned TIME_W       = 32;
   localparam int unsigned TRANS_W      = 2;
   localparam int unsigned ACTIVE_W     = 3;

   // Channel storage; the request can address at most four entries.
   localparam int unsigned DEF_NUM_CHANNELS = 4;
   localparam int unsigned MAX_CHANNELS     = 8;
   localparam int unsigned CH_CMP_W         = 3;

   // Configuration port.
   localparam int unsigned NUM_TIMEOUT_REGS = 4;
   localparam int unsigned CSR_ADDR_W       = 5;
   localparam int unsigned CSR_DATA_W       = 32;
   localparam int unsigned REG_IDX_W        = 3;

   localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd100;

   // Register indexes; the byte address is four times the index.
   typedef enum logic [REG_IDX_W-1:0] {
      REG_TIMEOUT_CH0  = 3'd0,
      REG_TIMEOUT_CH1  = 3'd1,
      REG_TIMEOUT_CH2  = 3'd2,
      REG_TIMEOUT_CH3  = 3'd3,
      REG_ACTIVE_COUNT = 3'd4
   } reg_idx_type;

   // Transition codes.
   localparam logic [TRANS_W-1:0] TR_NONE    = 2'd0;
   localparam logic [TRANS_W-1:0] TR_OFFLINE = 2'd1;
   localparam logic [TRANS_W-1:0] TR_ONLINE  = 2'd2;

   // Request modes.
   localparam logic MODE_FEED  = 1'b0;
   localparam logic MODE_CHECK = 1'b1;

endpackage : hbtm_pkg

`default_nettype wire

// File: rtl/core/heartbeat_timeout_monitor.sv
// ============================================================================
// Heartbeat timeout monitor
// Per-channel watchdog: feeds record the time, checks detect timeouts and
// report online and offline transitions.
// ============================================================================
//
//   Channel   Handshake                    Payload
//   --------  ---------------------------  -----------------------------------
//   request   start high, busy low         req_mode, req_channel, req_now_ms
//   result    rsp_strobe, one cycle        rsp_channel_out, rsp_transition,
//                                          rsp_is_online, rsp_offline_duration,
//                                          rsp_last_feed_time,
//                                          rsp_stored_transition
//   config    psel, penable, pwrite        paddr, pwdata, prdata, pready
//
// One request is taken in every cycle; busy stays low.
// An accepted request loads the request register, and the channel update then
// loads the result register, which drives the strobe and the result.
// Channel state is written at the same edge as the result, so a following
// request to the same channel sees the updated state without forwarding.
// Synchronous reset clears all channel state and restores the configuration registers.
// The receiver cannot stall; every result is shown for exactly one cycle.
// ============================================================================
`default_nettype none

module heartbeat_timeout_monitor
   import hbtm_pkg::*;
#(
   parameter int unsigned NUM_CHANNELS = DEF_NUM_CHANNELS
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // Request channel
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic                    req_mode,
   input  wire logic [CHANNEL_W-1:0]    req_channel,
   input  wire logic [TIME_W-1:0]       req_now_ms,
   // Result channel
   output logic                         rsp_strobe,
   output logic [CHANNEL_W-1:0]         rsp_channel_out,
   output logic [TRANS_W-1:0]           rsp_transition,
   output logic                         rsp_is_online,
   output logic [TIME_W-1:0]            rsp_offline_duration,
   output logic [TIME_W-1:0]            rsp_last_feed_time,
   output logic [TRANS_W-1:0]           rsp_stored_transition,
   // Configuration port
   input  wire logic                    psel,
   input  wire logic                    penable,
   input  wire logic                    pwrite,
   input  wire logic [CSR_ADDR_W-1:0]   paddr,
   input  wire logic [CSR_DATA_W-1:0]   pwdata,
   output logic [CSR_DATA_W-1:0]        prdata,
   output logic                         pready
);

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [TIME_W-1:0]   timeout_ff [NUM_TIMEOUT_REGS];
   logic [ACTIVE_W-1:0] active_count_ff;
   reg_idx_type         csr_idx;
   logic                csr_write;

   assign pready    = 1'b1;
   assign csr_idx   = reg_idx_type'(paddr[CSR_ADDR_W-1:2]);
   assign csr_write = psel && penable && pwrite && pready;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TIMEOUT_REGS; i++) begin
            timeout_ff[i] <= TIMEOUT_RESET;
         end
         active_count_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_idx)
            REG_TIMEOUT_CH0:  timeout_ff[0]   <= pwdata;
            REG_TIMEOUT_CH1:  timeout_ff[1]   <= pwdata;
            REG_TIMEOUT_CH2:  timeout_ff[2]   <= pwdata;
            REG_TIMEOUT_CH3:  timeout_ff[3]   <= pwdata;
            REG_ACTIVE_COUNT: active_count_ff <= pwdata[ACTIVE_W-1:0];
            default: ;
         endcase
      end
   end

   // Register reads.
   always_comb begin
      unique case (csr_idx)
         REG_TIMEOUT_CH0:  prdata = timeout_ff[0];
         REG_TIMEOUT_CH1:  prdata = timeout_ff[1];
         REG_TIMEOUT_CH2:  prdata = timeout_ff[2];
         REG_TIMEOUT_CH3:  prdata = timeout_ff[3];
         REG_ACTIVE_COUNT: prdata = {{(CSR_DATA_W-ACTIVE_W){1'b0}}, active_count_ff};
         default:          prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Request register
   // ------------------------------------------------------------------------
   logic                 in_valid_ff;
   logic                 in_mode_ff;
   logic [CHANNEL_W-1:0] in_channel_ff;
   logic [TIME_W-1:0]    in_now_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         in_mode_ff    <= req_mode;
         in_channel_ff <= req_channel;
         in_now_ff     <= req_now_ms;
      end
   end

   // ------------------------------------------------------------------------
   // Channel state
   // ------------------------------------------------------------------------
   logic                online_ff   [NUM_CHANNELS];
   logic                pending_ff  [NUM_CHANNELS];
   logic [TIME_W-1:0]   feed_ff     [NUM_CHANNELS];
   logic [TIME_W-1:0]   offstart_ff [NUM_CHANNELS];
   logic [TRANS_W-1:0]  rec_ff      [NUM_CHANNELS];

   logic [NUM_CHANNELS-1:0] hit;
   logic                cur_exists;
   logic                cur_online;
   logic                cur_pending;
   logic [TIME_W-1:0]   cur_feed;
   logic [TIME_W-1:0]   cur_offstart;
   logic [TRANS_W-1:0]  cur_rec;

   // Select the addressed entry; a channel without storage reads as reset.
   always_comb begin
      cur_exists   = 1'b0;
      cur_online   = 1'b0;
      cur_pending  = 1'b0;
      cur_feed     = '0;
      cur_offstart = '0;
      cur_rec      = TR_NONE;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         hit[i] = ({1'b0, in_channel_ff} == CH_CMP_W'(i));
         if (hit[i]) begin
            cur_exists   = 1'b1;
            cur_online   = online_ff[i];
            cur_pending  = pending_ff[i];
            cur_feed     = feed_ff[i];
            cur_offstart = offstart_ff[i];
            cur_rec      = rec_ff[i];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Feed and check update
   // ------------------------------------------------------------------------
   logic                upd;
   logic [TIME_W-1:0]   elapsed;
   logic                expired;
   logic                nxt_online;
   logic                nxt_pending;
   logic [TIME_W-1:0]   nxt_feed;
   logic [TIME_W-1:0]   nxt_offstart;
   logic [TRANS_W-1:0]  nxt_rec;
   logic [TRANS_W-1:0]  trans;

   assign upd     = in_valid_ff && cur_exists && ({1'b0, in_channel_ff} < active_count_ff);
   assign elapsed = in_now_ff - cur_feed;
   assign expired = cur_online && (elapsed >= timeout_ff[in_channel_ff]);

   always_comb begin
      nxt_online   = cur_online;
      nxt_pending  = cur_pending;
      nxt_feed     = cur_feed;
      nxt_offstart = cur_offstart;
      nxt_rec      = cur_rec;
      trans        = TR_NONE;
      if (upd) begin
         if (in_mode_ff == MODE_FEED) begin
            // A feed brings an offline channel online.
            nxt_feed = in_now_ff;
            if (!cur_online) begin
               nxt_online  = 1'b1;
               nxt_pending = 1'b1;
               nxt_rec     = TR_ONLINE;
            end
         end else begin
            // A check times out, reports a pending online event once, or reports no transition.
            priority if (expired) begin
               nxt_online   = 1'b0;
               nxt_pending  = 1'b0;
               nxt_offstart = in_now_ff;
               trans        = TR_OFFLINE;
            end else if (cur_pending) begin
               nxt_pending = 1'b0;
               trans       = TR_ONLINE;
            end else begin
               trans = TR_NONE;
            end
            nxt_rec = trans;
         end
      end
   end

   // State write-back into the addressed entry.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            online_ff[i]   <= 1'b0;
            pending_ff[i]  <= 1'b0;
            feed_ff[i]     <= '0;
            offstart_ff[i] <= '0;
            rec_ff[i]      <= TR_NONE;
         end
      end else begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (upd && hit[i]) begin
               online_ff[i]   <= nxt_online;
               pending_ff[i]  <= nxt_pending;
               feed_ff[i]     <= nxt_feed;
               offstart_ff[i] <= nxt_offstart;
               rec_ff[i]      <= nxt_rec;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result register
   // ------------------------------------------------------------------------
   logic                 rsp_strobe_ff;
   logic [CHANNEL_W-1:0] rsp_channel_ff;
   logic [TRANS_W-1:0]   rsp_trans_ff;
   logic                 rsp_online_ff;
   logic [TIME_W-1:0]    rsp_duration_ff;
   logic [TIME_W-1:0]    rsp_feed_ff;
   logic [TRANS_W-1:0]   rsp_rec_ff;
   logic [TIME_W-1:0]    rsp_duration_in;

   assign rsp_duration_in = nxt_online ? '0 : (in_now_ff - nxt_offstart);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_ff) begin
         rsp_channel_ff  <= in_channel_ff;
         rsp_trans_ff    <= trans;
         rsp_online_ff   <= nxt_online;
         rsp_duration_ff <= rsp_duration_in;
         rsp_feed_ff     <= nxt_feed;
         rsp_rec_ff      <= nxt_rec;
      end
   end

   assign rsp_strobe            = rsp_strobe_ff;
   assign rsp_channel_out       = rsp_channel_ff;
   assign rsp_transition        = rsp_trans_ff;
   assign rsp_is_online         = rsp_online_ff;
   assign rsp_offline_duration  = rsp_duration_ff;
   assign rsp_last_feed_time    = rsp_feed_ff;
   assign rsp_stored_transition = rsp_rec_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
`ifndef SYNTHESIS
   // Every accepted request yields a result strobe.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe_ff)
      else $error("accepted request produced no result");

   // A feed never reports a transition.
   a_feed_no_trans: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && in_mode_ff == MODE_FEED) |=> (rsp_trans_ff == TR_NONE))
      else $error("feed reported a transition");

   // An offline transition leaves the channel offline.
   a_offline_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_trans_ff == TR_OFFLINE) |-> !rsp_online_ff)
      else $error("offline transition with channel still online");

   // An online channel reports no offline duration.
   a_online_dur: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_online_ff) |-> (rsp_duration_ff == '0))
      else $error("online channel with nonzero offline duration");

   // A pending online event implies the channel is online.
   a_pending_online: assert property (@(posedge clock) disable iff (reset)
      (upd && cur_pending) |-> cur_online)
      else $error("pending online event on an offline channel");
`endif

endmodule : heartbeat_timeout_monitor

`default_nettype wire

// File: sim/heartbeat_timeout_monitor_test.sv
`timescale 1ns / 1ps
// ============================================================================
// Heartbeat timeout monitor testbench
// Drives feed and check requests and configuration writes into the monitor.
// A scoreboard keeps its own copy of the channel table and the registers,
// predicts each result and compares it field by field in arrival order.
// ============================================================================

// One result of the monitor, as predicted or as seen on the result ports.
typedef struct packed {
   logic [hbtm_pkg::CHANNEL_W-1:0] channel_out;
   logic [hbtm_pkg::TRANS_W-1:0]   transition;
   logic                           is_online;
   logic [hbtm_pkg::TIME_W-1:0]    offline_duration;
   logic [hbtm_pkg::TIME_W-1:0]    last_feed_time;
   logic [hbtm_pkg::TRANS_W-1:0]   stored_transition;
} heartbeat_report_type;

// Channel table, register copy and the queue of predicted results.
class heartbeat_scoreboard;
   logic [hbtm_pkg::TIME_W-1:0]   timeout_regs [hbtm_pkg::NUM_TIMEOUT_REGS];
   logic [hbtm_pkg::ACTIVE_W-1:0] active_count;
   logic                          online [hbtm_pkg::DEF_NUM_CHANNELS];
   logic                          pending_online [hbtm_pkg::DEF_NUM_CHANNELS];
   logic [hbtm_pkg::TIME_W-1:0]   fed_at [hbtm_pkg::DEF_NUM_CHANNELS];
   logic [hbtm_pkg::TIME_W-1:0]   offline_at [hbtm_pkg::DEF_NUM_CHANNELS];
   logic [hbtm_pkg::TRANS_W-1:0]  last_transition [hbtm_pkg::DEF_NUM_CHANNELS];
   heartbeat_report_type          predicted_reports [$];
   int unsigned mismatches;
   int unsigned requests_noted;
   int unsigned reports_checked;
   int unsigned offline_events;
   int unsigned online_events;

   function new();
      for (int i = 0; i < hbtm_pkg::NUM_TIMEOUT_REGS; i++) begin
         timeout_regs[i] = hbtm_pkg::TIMEOUT_RESET;
      end
      active_count = '0;
      for (int i = 0; i < hbtm_pkg::DEF_NUM_CHANNELS; i++) begin
         online[i]          = 1'b0;
         pending_online[i]  = 1'b0;
         fed_at[i]          = '0;
         offline_at[i]      = '0;
         last_transition[i] = hbtm_pkg::TR_NONE;
      end
      mismatches      = 0;
      requests_noted  = 0;
      reports_checked = 0;
      offline_events  = 0;
      online_events   = 0;
   endfunction

   // Mirrors a register write; unknown indexes leave everything unchanged.
   function void write_register(logic [hbtm_pkg::REG_IDX_W-1:0] idx,
                                logic [hbtm_pkg::CSR_DATA_W-1:0] value);
      case (idx)
         hbtm_pkg::REG_TIMEOUT_CH0, hbtm_pkg::REG_TIMEOUT_CH1,
         hbtm_pkg::REG_TIMEOUT_CH2, hbtm_pkg::REG_TIMEOUT_CH3: begin
            timeout_regs[idx[1:0]] = value;
         end
         hbtm_pkg::REG_ACTIVE_COUNT: begin
            active_count = value[hbtm_pkg::ACTIVE_W-1:0];
         end
         default: begin
         end
      endcase
   endfunction

   // Applies one accepted request to the channel table and queues its result.
   function void note_request(logic mode, logic [hbtm_pkg::CHANNEL_W-1:0] ch,
                              logic [hbtm_pkg::TIME_W-1:0] now);
      heartbeat_report_type r;
      logic [hbtm_pkg::TIME_W-1:0] elapsed;
      r.channel_out = ch;
      r.transition  = hbtm_pkg::TR_NONE;
      elapsed       = now - fed_at[ch];
      // Channels at or above the active count keep their state.
      if ({1'b0, ch} < active_count) begin
         if (mode == hbtm_pkg::MODE_FEED) begin
            fed_at[ch] = now;
            if (!online[ch]) begin
               online[ch]          = 1'b1;
               pending_online[ch]  = 1'b1;
               last_transition[ch] = hbtm_pkg::TR_ONLINE;
            end
         end else begin
            if (online[ch] && elapsed >= timeout_regs[ch]) begin
               online[ch]         = 1'b0;
               pending_online[ch] = 1'b0;
               offline_at[ch]     = now;
               r.transition       = hbtm_pkg::TR_OFFLINE;
            end else if (pending_online[ch]) begin
               pending_online[ch] = 1'b0;
               r.transition       = hbtm_pkg::TR_ONLINE;
            end
            last_transition[ch] = r.transition;
         end
      end
      r.is_online         = online[ch];
      r.offline_duration  = online[ch] ? '0 : now - offline_at[ch];
      r.last_feed_time    = fed_at[ch];
      r.stored_transition = last_transition[ch];
      predicted_reports.push_back(r);
      requests_noted++;
   endfunction

   function void compare_field(string name, logic [31:0] expected, logic [31:0] actual);
      if (actual !== expected) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, expected, actual);
         mismatches++;
      end
   endfunction

   // Compares one result with the oldest prediction.
   function void check_report(heartbeat_report_type got);
      heartbeat_report_type want;
      if (predicted_reports.size() == 0) begin
         $error("result on channel %0d with no request outstanding", got.channel_out);
         mismatches++;
         return;
      end
      want = predicted_reports.pop_front();
      reports_checked++;
      if (want.transition == hbtm_pkg::TR_OFFLINE) offline_events++;
      if (want.transition == hbtm_pkg::TR_ONLINE) online_events++;
      compare_field("channel_out", 32'(want.channel_out), 32'(got.channel_out));
      compare_field("transition", 32'(want.transition), 32'(got.transition));
      compare_field("is_online", 32'(want.is_online), 32'(got.is_online));
      compare_field("offline_duration", want.offline_duration, got.offline_duration);
      compare_field("last_feed_time", want.last_feed_time, got.last_feed_time);
      compare_field("stored_transition", 32'(want.stored_transition),
                    32'(got.stored_transition));
   endfunction

   function int unsigned outstanding();
      return predicted_reports.size();
   endfunction
endclass

module heartbeat_timeout_monitor_test;
   import hbtm_pkg::*;

   localparam int unsigned LIMIT_CYCLES  = 200000;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned PHASE_ITEMS   = 275;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic                  req_mode;
   logic [CHANNEL_W-1:0]  req_channel;
   logic [TIME_W-1:0]     req_now_ms;
   logic                  rsp_strobe;
   logic [CHANNEL_W-1:0]  rsp_channel_out;
   logic [TRANS_W-1:0]    rsp_transition;
   logic                  rsp_is_online;
   logic [TIME_W-1:0]     rsp_offline_duration;
   logic [TIME_W-1:0]     rsp_last_feed_time;
   logic [TRANS_W-1:0]    rsp_stored_transition;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   heartbeat_scoreboard sb = new();
   int unsigned cycle_count = 0;
   int unsigned sender_idle_pct = 0;
   int unsigned register_writes = 0;
   logic [TIME_W-1:0] time_ms;

   heartbeat_timeout_monitor u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_mode              (req_mode),
      .req_channel           (req_channel),
      .req_now_ms            (req_now_ms),
      .rsp_strobe            (rsp_strobe),
      .rsp_channel_out       (rsp_channel_out),
      .rsp_transition        (rsp_transition),
      .rsp_is_online         (rsp_is_online),
      .rsp_offline_duration  (rsp_offline_duration),
      .rsp_last_feed_time    (rsp_last_feed_time),
      .rsp_stored_transition (rsp_stored_transition),
      .psel                  (psel),
      .penable               (penable),
      .pwrite                (pwrite),
      .paddr                 (paddr),
      .pwdata                (pwdata),
      .prdata                (prdata),
      .pready                (pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Notes accepted requests and checks results at each rising edge.
   always @(posedge clock) begin : monitor
      heartbeat_report_type seen;
      cycle_count++;
      if (!reset) begin
         if (start && !busy) sb.note_request(req_mode, req_channel, req_now_ms);
         if (rsp_strobe) begin
            seen.channel_out       = rsp_channel_out;
            seen.transition        = rsp_transition;
            seen.is_online         = rsp_is_online;
            seen.offline_duration  = rsp_offline_duration;
            seen.last_feed_time    = rsp_last_feed_time;
            seen.stored_transition = rsp_stored_transition;
            sb.check_report(seen);
         end
      end
   end

   // Ends a hung run.
   initial begin
      while (cycle_count < LIMIT_CYCLES) @(posedge clock);
      $display("** heartbeat_timeout_monitor: FAILED **");
      $finish;
   end

   // Presents one request, with random idle cycles ahead of it.
   task automatic send_request(logic mode, logic [CHANNEL_W-1:0] ch, logic [TIME_W-1:0] now);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start       = 1'b1;
      req_mode    = mode;
      req_channel = ch;
      req_now_ms  = now;
      do @(posedge clock); while (busy);
   endtask

   // Holds off new requests until every predicted result has arrived.
   task automatic wait_for_reports();
      @(negedge clock);
      start = 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(logic [REG_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      sb.write_register(idx, value);
      register_writes++;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic read_register(logic [REG_IDX_W-1:0] idx, output logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = {idx, 2'b00};
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      value = prdata;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   // Writes all registers while the monitor is idle, then reads them back.
   task automatic configure(logic [TIME_W-1:0] t0, logic [TIME_W-1:0] t1,
                            logic [TIME_W-1:0] t2, logic [TIME_W-1:0] t3,
                            logic [ACTIVE_W-1:0] active);
      logic [CSR_DATA_W-1:0] readback;
      wait_for_reports();
      write_register(REG_TIMEOUT_CH0, t0);
      write_register(REG_TIMEOUT_CH1, t1);
      write_register(REG_TIMEOUT_CH2, t2);
      write_register(REG_TIMEOUT_CH3, t3);
      write_register(REG_ACTIVE_COUNT, {29'd0, active});
      for (int i = REG_TIMEOUT_CH0; i <= REG_TIMEOUT_CH3; i++) begin
         read_register(i[REG_IDX_W-1:0], readback);
         sb.compare_field("timeout readback", sb.timeout_regs[i[1:0]], readback);
      end
      read_register(REG_ACTIVE_COUNT, readback);
      sb.compare_field("active_count readback", {29'd0, sb.active_count}, readback);
   endtask

   // Mostly feeds and checks with time moving forward, some random times.
   task automatic run_random_phase(int unsigned idle_pct);
      logic              mode;
      logic [TIME_W-1:0] now;
      sender_idle_pct = idle_pct;
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
         // Halfway through, pause until idle and change the active count.
         if (i == PHASE_ITEMS / 2) begin
            wait_for_reports();
            write_register(REG_ACTIVE_COUNT, $urandom_range(1, 7));
         end
         if ($urandom_range(99) < 80) begin
            time_ms = time_ms + $urandom_range(0, 9);
            now     = time_ms;
         end else begin
            now = $urandom();
         end
         mode = ($urandom_range(99) < 40) ? MODE_FEED : MODE_CHECK;
         send_request(mode, CHANNEL_W'($urandom_range(3)), now);
      end
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_mode    = MODE_FEED;
      req_channel = '0;
      req_now_ms  = '0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // No channel is active after reset; requests only report the table.
      send_request(MODE_FEED, 2'd0, 32'd0);
      send_request(MODE_CHECK, 2'd3, 32'hFFFF_FFFF);

      // Zero timeout, largest timeout, default and a short one; all active.
      configure(32'd0, 32'hFFFF_FFFF, 32'd100, 32'd5, 3'd4);
      write_register(3'd5, 32'hDEAD_BEEF);
      write_register(3'd7, 32'hFFFF_FFFF);

      // A never-fed channel reports the time itself as offline duration.
      send_request(MODE_CHECK, 2'd1, 32'hFFFF_FFFF);
      // Zero timeout: any check of an online channel takes it offline.
      send_request(MODE_FEED, 2'd0, 32'd10);
      send_request(MODE_CHECK, 2'd0, 32'd10);
      send_request(MODE_CHECK, 2'd0, 32'd15);
      send_request(MODE_FEED, 2'd0, 32'd20);
      send_request(MODE_FEED, 2'd0, 32'd21);
      // Feed just before the time wraps, then check on both sides of the limit.
      send_request(MODE_FEED, 2'd2, 32'hFFFF_FFF0);
      send_request(MODE_CHECK, 2'd2, 32'h0000_0010);
      send_request(MODE_CHECK, 2'd2, 32'h0000_0010);
      send_request(MODE_CHECK, 2'd2, 32'h0000_0053);
      send_request(MODE_CHECK, 2'd2, 32'h0000_0054);
      send_request(MODE_CHECK, 2'd2, 32'h0000_0060);
      // Largest timeout is reached only by a full wrap of the elapsed time.
      send_request(MODE_FEED, 2'd1, 32'd5);
      send_request(MODE_CHECK, 2'd1, 32'd4);
      send_request(MODE_FEED, 2'd1, 32'd0);
      send_request(MODE_CHECK, 2'd1, 32'hFFFF_FFFE);
      send_request(MODE_CHECK, 2'd1, 32'hFFFF_FFFE);
      send_request(MODE_FEED, 2'd3, 32'd100);
      send_request(MODE_CHECK, 2'd3, 32'd104);
      send_request(MODE_CHECK, 2'd3, 32'd105);

      // Channels at or above the active count are ignored.
      wait_for_reports();
      write_register(REG_ACTIVE_COUNT, 32'd2);
      send_request(MODE_FEED, 2'd3, 32'd500);
      send_request(MODE_CHECK, 2'd2, 32'd900);

      // Random phases with different timeouts, idle rates and time bases.
      configure($urandom_range(1, 40), $urandom_range(1, 40),
                $urandom_range(1, 40), $urandom_range(1, 40), 3'd4);
      time_ms = $urandom();
      run_random_phase(33);

      configure(32'hFFFF_FFFF, $urandom_range(1, 40), $urandom_range(5, 60), 32'd0, 3'd3);
      time_ms = 32'hFFFF_FF80;
      run_random_phase(55);

      configure($urandom_range(1, 30), $urandom_range(1, 30), $urandom(),
                $urandom_range(0, 60), 3'd7);
      time_ms = $urandom();
      run_random_phase(0);

      wait_for_reports();
      $display("Run covered %0d requests and %0d results, with %0d offline and %0d online",
               sb.requests_noted, sb.reports_checked, sb.offline_events, sb.online_events);
      $display("transitions reported, over %0d register writes.", register_writes);
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("** heartbeat_timeout_monitor: PASSED **");
      end else begin
         $display("** heartbeat_timeout_monitor: FAILED **");
      end
      $finish;
   end

endmodule
